// ===== rtl/core/acse_pkg.sv =====
// ----------------------------------------------------------------------------
// Adler checksum XOR encoder package
// Shared constants, register indexes, queue entry type and the modular add.
// ----------------------------------------------------------------------------
package acse_pkg;

   // Checksum arithmetic.
   localparam logic [15:0] ADLER_MOD = 16'hFFF1;

   // Key storage.
   localparam int MAX_KEY_BYTES = 16;
   localparam int KEY_POS_W     = $clog2(MAX_KEY_BYTES);
   localparam int KEY_LEN_W     = 5;
   localparam int KEY_WORD_W    = 64;

   localparam logic [KEY_WORD_W-1:0] KEY_LOW_RESET  = 64'h7267_5A59_7261_5453;
   localparam logic [KEY_WORD_W-1:0] KEY_HIGH_RESET = 64'h0000_0031_314C_4433;
   localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RESET  = 5'd13;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 2'd2;

   // Request commands.
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Trailer and queue geometry.
   localparam int TRAILER_BYTES = 4;
   localparam int TRAILER_IDX_W = $clog2(TRAILER_BYTES);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = QUEUE_PTR_W + 1;

   // One classified request on its way from the front to the back.
   // For a data byte, word[7:0] holds the encrypted byte.
   typedef struct packed {
      logic        is_end;
      logic [31:0] word;
   } queue_entry_type;

   // Sum of two residues, reduced once modulo ADLER_MOD.
   function automatic logic [15:0] add_mod(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      logic [16:0] diff;
      sum  = {1'b0, a} + {1'b0, b};
      diff = sum - {1'b0, ADLER_MOD};
      return (sum >= {1'b0, ADLER_MOD}) ? diff[15:0] : sum[15:0];
   endfunction

endpackage

// ===== rtl/core/adler_checksum_xor_save_encoder.sv =====
// ----------------------------------------------------------------------------
// Adler checksum XOR encoder
// Encrypts a byte stream with a repeating key and appends an Adler-style
// checksum trailer on each end request.
// ----------------------------------------------------------------------------
// A data request (cmd 0) returns one response: the byte XORed with the next
// key byte, while both checksum sums (starting at zero, modulo 65521) advance
// over the plain byte. An end request (cmd 1) returns four trailer responses,
// least significant checksum byte first, with last on the fourth, then clears
// the sums and the key position. Data requests are taken one per cycle while
// the queue has room; an end request holds the response port for its four
// trailer bytes, and a four-entry queue between the front end and the response
// register absorbs that and any response stall. Responses pass the queue, then
// the response register. The key registers may be written only while idle.
// ----------------------------------------------------------------------------
module adler_checksum_xor_save_encoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [acse_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [acse_pkg::KEY_WORD_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [7:0]                          req_data_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_is_trailer,
   output logic                                rsp_last
);

   acse_pkg::queue_entry_type push_entry;
   acse_pkg::queue_entry_type head_entry;
   logic                      queue_push;
   logic                      queue_pop;
   logic                      queue_full;
   logic                      queue_empty;

   // Key registers, checksum state and request classification.
   acse_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .queue_push    (queue_push),
      .queue_entry   (push_entry)
   );

   // Decoupling queue.
   acse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .pop        (queue_pop),
      .head_entry (head_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // Response serializer and output register.
   acse_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .queue_empty    (queue_empty),
      .queue_pop      (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_trailer (rsp_is_trailer),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== rtl/core/acse_front.sv =====
// ----------------------------------------------------------------------------
// Adler checksum XOR encoder front end
// Holds the key registers and checksum state, classifies each request and
// pushes either an encrypted byte or a finished checksum into the queue.
// ----------------------------------------------------------------------------
module acse_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_en,
   input  logic [acse_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [acse_pkg::KEY_WORD_W-1:0]         csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_cmd,
   input  logic [7:0]                              req_data_byte,
   input  logic                                    queue_full,
   output logic                                    queue_push,
   output acse_pkg::queue_entry_type               queue_entry
);

   logic [acse_pkg::KEY_WORD_W-1:0] key_low_ff, key_low_in;
   logic [acse_pkg::KEY_WORD_W-1:0] key_high_ff, key_high_in;
   logic [acse_pkg::KEY_LEN_W-1:0]  key_len_ff, key_len_in;
   logic [15:0]                     byte_sum_ff, byte_sum_in;
   logic [15:0]                     run_sum_ff, run_sum_in;
   logic [acse_pkg::KEY_POS_W-1:0]  key_pos_ff, key_pos_in;

   logic [acse_pkg::KEY_LEN_W-1:0]  eff_len;
   logic [acse_pkg::KEY_LEN_W-1:0]  pos_next;
   logic [2*acse_pkg::KEY_WORD_W-1:0] key_all;
   logic [7:0]                      key_byte;
   logic [15:0]                     byte_sum_add;
   logic [15:0]                     run_sum_add;

   // The front only waits when the queue has no room.
   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   // Key length clamped to one through MAX_KEY_BYTES.
   always_comb begin
      eff_len = key_len_ff;
      if (key_len_ff == '0) begin
         eff_len = acse_pkg::KEY_LEN_W'(1);
      end else if (key_len_ff > acse_pkg::KEY_LEN_W'(acse_pkg::MAX_KEY_BYTES)) begin
         eff_len = acse_pkg::KEY_LEN_W'(acse_pkg::MAX_KEY_BYTES);
      end
   end

   // Key byte at the current position and the next position, wrapping at the length.
   assign key_all  = {key_high_ff, key_low_ff};
   assign key_byte = key_all[{key_pos_ff, 3'b000} +: 8];
   assign pos_next = {1'b0, key_pos_ff} + acse_pkg::KEY_LEN_W'(1);

   // Both sums advance over the plain byte.
   assign byte_sum_add = acse_pkg::add_mod(byte_sum_ff, {8'h00, req_data_byte});
   assign run_sum_add  = acse_pkg::add_mod(run_sum_ff, byte_sum_add);

   // Build the queue entry for this request.
   always_comb begin
      queue_entry.is_end = (req_cmd == acse_pkg::CMD_END);
      if (req_cmd == acse_pkg::CMD_END) begin
         queue_entry.word = {run_sum_ff, byte_sum_ff};
      end else begin
         queue_entry.word = {24'h000000, req_data_byte ^ key_byte};
      end
   end

   // Next state of the checksum and key position.
   always_comb begin
      byte_sum_in = byte_sum_ff;
      run_sum_in  = run_sum_ff;
      key_pos_in  = key_pos_ff;
      if (queue_push) begin
         if (req_cmd == acse_pkg::CMD_END) begin
            byte_sum_in = '0;
            run_sum_in  = '0;
            key_pos_in  = '0;
         end else begin
            byte_sum_in = byte_sum_add;
            run_sum_in  = run_sum_add;
            key_pos_in  = (pos_next >= eff_len) ? '0 : pos_next[acse_pkg::KEY_POS_W-1:0];
         end
      end
   end

   // Configuration register writes.
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      key_len_in  = key_len_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            acse_pkg::CSR_KEY_LOW:    key_low_in  = csr_wdata;
            acse_pkg::CSR_KEY_HIGH:   key_high_in = csr_wdata;
            acse_pkg::CSR_KEY_LENGTH: key_len_in  = csr_wdata[acse_pkg::KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= acse_pkg::KEY_LOW_RESET;
         key_high_ff <= acse_pkg::KEY_HIGH_RESET;
         key_len_ff  <= acse_pkg::KEY_LEN_RESET;
         byte_sum_ff <= '0;
         run_sum_ff  <= '0;
         key_pos_ff  <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         key_len_ff  <= key_len_in;
         byte_sum_ff <= byte_sum_in;
         run_sum_ff  <= run_sum_in;
         key_pos_ff  <= key_pos_in;
      end
   end

endmodule

// ===== rtl/core/acse_queue.sv =====
// ----------------------------------------------------------------------------
// Adler checksum XOR encoder queue
// Small first-in first-out buffer of classified requests between the front
// and the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module acse_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  acse_pkg::queue_entry_type  push_entry,
   input  logic                       pop,
   output acse_pkg::queue_entry_type  head_entry,
   output logic                       full,
   output logic                       empty
);

   acse_pkg::queue_entry_type         entries_ff [acse_pkg::QUEUE_DEPTH];
   logic [acse_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [acse_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [acse_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == acse_pkg::QUEUE_CNT_W'(acse_pkg::QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + acse_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + acse_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + acse_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - acse_pkg::QUEUE_CNT_W'(1);
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= acse_pkg::QUEUE_CNT_W'(acse_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue pushed while full");
`endif

endmodule

// ===== rtl/core/acse_back.sv =====
// ----------------------------------------------------------------------------
// Adler checksum XOR encoder back end
// Takes classified requests from the queue and drives the response register:
// one byte for a data request, four trailer bytes for an end request.
// ----------------------------------------------------------------------------
module acse_back (
   input  logic                       clock,
   input  logic                       reset,
   input  acse_pkg::queue_entry_type  head_entry,
   input  logic                       queue_empty,
   output logic                       queue_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_is_trailer,
   output logic                       rsp_last
);

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [7:0]                          out_byte_ff, out_byte_in;
   logic                                is_trailer_ff, is_trailer_in;
   logic                                last_ff, last_in;
   logic [acse_pkg::TRAILER_IDX_W-1:0]  trail_idx_ff, trail_idx_in;

   logic                                load;
   logic                                trail_done;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_is_trailer = is_trailer_ff;
   assign rsp_last       = last_ff;

   // The response register refills whenever it is empty or being taken.
   assign load       = !rsp_valid_ff || !rsp_stall;
   assign trail_done = (trail_idx_ff == acse_pkg::TRAILER_IDX_W'(acse_pkg::TRAILER_BYTES - 1));

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_byte_in   = out_byte_ff;
      is_trailer_in = is_trailer_ff;
      last_in       = last_ff;
      trail_idx_in  = trail_idx_ff;
      queue_pop     = 1'b0;
      if (load) begin
         rsp_valid_in = !queue_empty;
         if (!queue_empty) begin
            if (head_entry.is_end) begin
               // Checksum trailer, least significant byte first.
               out_byte_in   = head_entry.word[{trail_idx_ff, 3'b000} +: 8];
               is_trailer_in = 1'b1;
               last_in       = trail_done;
               trail_idx_in  = trail_idx_ff + acse_pkg::TRAILER_IDX_W'(1);
               queue_pop     = trail_done;
            end else begin
               out_byte_in   = head_entry.word[7:0];
               is_trailer_in = 1'b0;
               last_in       = 1'b1;
               queue_pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         trail_idx_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         trail_idx_ff <= trail_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      is_trailer_ff <= is_trailer_in;
      last_ff       <= last_in;
   end

`ifndef SYNTHESIS
   a_trail_mid: assert property (@(posedge clock) disable iff (reset)
      trail_idx_ff != '0 |-> rsp_valid_ff && is_trailer_ff && !last_ff)
      else $error("trailer index set outside a trailer");

   a_data_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !is_trailer_ff |-> last_ff)
      else $error("data response without last");

   a_last_resets_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> trail_idx_ff == '0)
      else $error("trailer index not cleared after last byte");
`endif

endmodule

// ===== tb/tb_adler_checksum_xor_save_encoder.sv =====
// ----------------------------------------------------------------------------
// Adler checksum XOR encoder testbench
// Drives byte and end-of-file requests through the encoder under random
// sender idles and response stalls, predicts every encrypted byte and checksum
// trailer in a scoreboard, and compares each response field by field.
// ----------------------------------------------------------------------------

// One response as the encoder should produce it.
typedef struct {
   logic [7:0] out_byte;
   logic       is_trailer;
   logic       last;
} coded_byte_type;

class encoder_scoreboard;
   logic [63:0] key_low;
   logic [63:0] key_high;
   logic [4:0]  key_length;
   logic [15:0] byte_sum;
   logic [15:0] running_sum;
   logic [3:0]  key_pos;
   coded_byte_type expected_bytes[$];
   int          requests;
   int          end_requests;
   int          checked;
   int          failures;

   function new();
      key_low      = acse_pkg::KEY_LOW_RESET;
      key_high     = acse_pkg::KEY_HIGH_RESET;
      key_length   = acse_pkg::KEY_LEN_RESET;
      byte_sum     = 16'd0;
      running_sum  = 16'd0;
      key_pos      = 4'd0;
      requests     = 0;
      end_requests = 0;
      checked      = 0;
      failures     = 0;
   endfunction

   function void set_register(logic [acse_pkg::CSR_INDEX_W-1:0] idx, logic [63:0] value);
      case (idx)
         acse_pkg::CSR_KEY_LOW: begin
            key_low = value;
         end
         acse_pkg::CSR_KEY_HIGH: begin
            key_high = value;
         end
         acse_pkg::CSR_KEY_LENGTH: begin
            key_length = value[4:0];
         end
         default: begin
         end
      endcase
   endfunction

   // Modular sum of two residues below the Adler modulus.
   function logic [15:0] fold_sum(logic [15:0] a, logic [15:0] b);
      logic [16:0] total;
      total = {1'b0, a} + {1'b0, b};
      if (total >= {1'b0, acse_pkg::ADLER_MOD}) begin
         total = total - {1'b0, acse_pkg::ADLER_MOD};
      end
      return total[15:0];
   endfunction

   // Works out the responses of one accepted request and advances the sums.
   function void note_request(logic cmd, logic [7:0] data);
      logic [4:0]  span;
      logic [4:0]  next_pos;
      logic [63:0] word;
      logic [31:0] checksum;
      coded_byte_type r;
      requests++;
      if (cmd == acse_pkg::CMD_DATA) begin
         // Length zero behaves as one, anything past the key store as its size.
         span = key_length;
         if (span == 5'd0) begin
            span = 5'd1;
         end
         if (span > 5'(acse_pkg::MAX_KEY_BYTES)) begin
            span = 5'(acse_pkg::MAX_KEY_BYTES);
         end
         word         = key_pos[3] ? key_high : key_low;
         r.out_byte   = data ^ word[key_pos[2:0]*8 +: 8];
         r.is_trailer = 1'b0;
         r.last       = 1'b1;
         expected_bytes.push_back(r);
         byte_sum    = fold_sum(byte_sum, {8'd0, data});
         running_sum = fold_sum(running_sum, byte_sum);
         // A position at or past a lowered length is used once, then wraps.
         next_pos = {1'b0, key_pos} + 5'd1;
         key_pos  = (next_pos >= span) ? 4'd0 : next_pos[3:0];
      end else begin
         end_requests++;
         checksum = {running_sum, byte_sum};
         for (int k = 0; k < acse_pkg::TRAILER_BYTES; k++) begin
            r.out_byte   = checksum[k*8 +: 8];
            r.is_trailer = 1'b1;
            r.last       = (k == acse_pkg::TRAILER_BYTES - 1);
            expected_bytes.push_back(r);
         end
         byte_sum    = 16'd0;
         running_sum = 16'd0;
         key_pos     = 4'd0;
      end
   endfunction

   // Compares one accepted response with the oldest expected one.
   function void check_response(logic [7:0] out_byte, logic is_trailer, logic last);
      coded_byte_type exp_r;
      if (expected_bytes.size() == 0) begin
         if (failures < 10) begin
            $display("ERROR: unexpected response byte=%02h trailer=%b last=%b",
                     out_byte, is_trailer, last);
         end
         failures++;
         return;
      end
      exp_r = expected_bytes.pop_front();
      checked++;
      if (out_byte !== exp_r.out_byte || is_trailer !== exp_r.is_trailer
          || last !== exp_r.last) begin
         if (failures < 10) begin
            $display("ERROR: response %0d expected byte=%02h trailer=%b last=%b,",
                     checked, exp_r.out_byte, exp_r.is_trailer, exp_r.last,
                     " got byte=%02h trailer=%b last=%b",
                     out_byte, is_trailer, last);
         end
         failures++;
      end
   endfunction

   function int pending();
      return expected_bytes.size();
   endfunction
endclass

module tb_adler_checksum_xor_save_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_write_en;
   logic [acse_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [acse_pkg::KEY_WORD_W-1:0]      csr_wdata;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_cmd;
   logic [7:0]                           req_data_byte;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [7:0]                           rsp_out_byte;
   logic                                 rsp_is_trailer;
   logic                                 rsp_last;

   encoder_scoreboard sb = new();
   int send_idle_pct = 34;
   int recv_idle_pct = 78;
   int hold_cycles   = 0;
   int key_settings  = 0;

   adler_checksum_xor_save_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_trailer (rsp_is_trailer),
      .rsp_last       (rsp_last)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever begin
         #6 clock = ~clock;
      end
   end

   // Run limit well beyond the slowest correct run.
   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   // Response side: a counted hold-off when asked, random stalls otherwise.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Observe both handshakes at the clock edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            sb.note_request(req_cmd, req_data_byte);
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            sb.check_response(rsp_out_byte, rsp_is_trailer, rsp_last);
         end
      end
   end

   // Offers one request and holds it until the encoder takes it.
   task automatic send_request(input logic cmd, input logic [7:0] data);
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_data_byte <= data;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      // Random sender idle cycles after the request.
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_bytes(input int count);
      for (int i = 0; i < count; i++) begin
         send_request(acse_pkg::CMD_DATA, 8'($urandom_range(255)));
      end
   endtask

   // Stops offering and waits until every expected response has arrived.
   task automatic drain();
      int n;
      n = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         n++;
      end while (sb.pending() != 0 && n < 50000);
      repeat (2) @(posedge clock);
   endtask

   // One register write; the encoder must be idle.
   task automatic write_csr(input logic [acse_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      sb.set_register(idx, value);
      csr_write_en <= 1'b0;
      @(posedge clock);
      key_settings++;
   endtask

   task automatic write_key(input logic [63:0] low, input logic [63:0] high,
                            input logic [4:0] len);
      write_csr(acse_pkg::CSR_KEY_LOW, low);
      write_csr(acse_pkg::CSR_KEY_HIGH, high);
      write_csr(acse_pkg::CSR_KEY_LENGTH, {59'd0, len});
   endtask

   // Random files: mostly short, now and then longer, each closed by an end.
   task automatic send_files(input int count);
      int sent;
      int file_len;
      sent = 0;
      while (sent < count) begin
         file_len = ($urandom_range(9) == 0) ? $urandom_range(25, 50) : $urandom_range(0, 12);
         send_bytes(file_len);
         send_request(acse_pkg::CMD_END, 8'($urandom_range(255)));
         sent += file_len + 1;
      end
      // Leave a file open so the next key change lands mid-file.
      send_bytes($urandom_range(1, 6));
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cmd       <= acse_pkg::CMD_DATA;
      req_data_byte <= 8'd0;
      csr_write_en  <= 1'b0;
      csr_index     <= acse_pkg::CSR_KEY_LOW;
      csr_wdata     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty file with the reset key; the data byte must be ignored.
      send_request(acse_pkg::CMD_END, 8'hFF);
      // Byte extremes under the reset key.
      send_request(acse_pkg::CMD_DATA, 8'h00);
      send_request(acse_pkg::CMD_DATA, 8'hFF);
      send_request(acse_pkg::CMD_DATA, 8'h80);
      send_request(acse_pkg::CMD_DATA, 8'h01);
      send_request(acse_pkg::CMD_END, 8'h00);
      drain();

      // A length of zero behaves as a one-byte key.
      write_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd0);
      send_bytes(3);
      send_request(acse_pkg::CMD_END, 8'h5A);
      drain();

      // A length past the key store uses all sixteen bytes.
      write_key(64'd0, {64{1'b1}}, 5'd31);
      send_bytes(10);
      drain();
      // Length lowered below the current position in the middle of a file.
      write_csr(acse_pkg::CSR_KEY_LENGTH, 64'd3);
      send_bytes(3);
      send_request(acse_pkg::CMD_END, 8'hA5);
      drain();

      // Receiver idles more than the sender; a long receiver hold fills the queue.
      write_key({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(1, 16)));
      hold_cycles = 90;
      send_files(70);
      drain();

      // Sender idles more than the receiver, one-byte key of all ones.
      send_idle_pct = 78;
      recv_idle_pct = 34;
      write_key({64{1'b1}}, 64'd0, 5'd1);
      send_files(70);
      drain();

      // No idling; full sixteen-byte key and one file long enough to wrap byte_sum.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
      send_request(acse_pkg::CMD_END, 8'($urandom_range(255)));
      for (int i = 0; i < 260; i++) begin
         send_request(acse_pkg::CMD_DATA, 8'($urandom_range(252, 255)));
      end
      send_request(acse_pkg::CMD_END, 8'($urandom_range(255)));
      send_files(25);
      send_request(acse_pkg::CMD_END, 8'($urandom_range(255)));
      drain();
      repeat (10) @(posedge clock);

      $display("Run covered %0d requests (%0d end of file) under %0d register writes,",
               sb.requests, sb.end_requests, key_settings);
      $display("with %0d responses checked and %0d responses still outstanding.",
               sb.checked, sb.pending());
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
